/* rtl/brs_pkg.sv */
// ----------------------------------------------------------------------------
// Byte range sector splitter package
// Widths, segment kind codes and the stage records shared by the splitter
// modules.
// ----------------------------------------------------------------------------
package brs_pkg;

  // Field widths.
  localparam int unsigned OFF_W = 48;   // request byte offset
  localparam int unsigned LEN_W = 32;   // request length, byte and sector counts
  localparam int unsigned SB_W  = 17;   // sector size register
  localparam int unsigned DEV_W = 40;   // device size register
  localparam int unsigned SEC_W = 48;   // sector numbers
  localparam int unsigned OIS_W = 16;   // offset_in_sector output field

  // Dividend width: the request end offset needs one bit more than the offset.
  localparam int unsigned QW = OFF_W + 1;

  // Segment kind codes.
  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_HEAD  = 2'd1;
  localparam logic [1:0] KIND_BULK  = 2'd2;
  localparam logic [1:0] KIND_TAIL  = 2'd3;

  // One divider stage: start and end offsets divided by the sector size
  // side by side. Each n field holds the dividend bits still to be consumed
  // in its upper part and the quotient bits already found in its lower part.
  typedef struct packed {
    logic            vld;
    logic            op;
    logic            nil;
    logic [QW-1:0]   n_off;
    logic [SB_W-1:0] r_off;
    logic [QW-1:0]   n_end;
    logic [SB_W-1:0] r_end;
  } brs_div_t;

  // A split request after the division, ready for segment selection.
  typedef struct packed {
    logic             vld;
    logic             op;
    logic             nil;
    logic [SEC_W-1:0] s;        // first sector of the request
    logic [SB_W-1:0]  o;        // offset within the first sector
    logic [SEC_W-1:0] sp;       // first sector after the head
    logic [SEC_W-1:0] e;        // sector of the clipped end
    logic [SB_W-1:0]  eo;       // offset of the clipped end in that sector
    logic [SB_W-1:0]  hb;       // head bytes
    logic [LEN_W-1:0] secs;     // whole sectors of the bulk run
    logic [LEN_W-1:0] bulk;     // bulk bytes
    logic             has_head;
    logic             has_bulk;
    logic             has_tail;
  } brs_seg_t;

endpackage

/* rtl/brs_div_stage.sv */
// ----------------------------------------------------------------------------
// Splitter divider stage
// One registered restoring division step, applied to the start and the end
// offset of a request at the same time.
// ----------------------------------------------------------------------------
module brs_div_stage import brs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [SB_W-1:0] sb_i,
  input  brs_div_t        d_i,
  output brs_div_t        q_o
);

  logic [SB_W:0]   cand_off, cand_end;
  logic            ge_off, ge_end;
  logic [SB_W:0]   diff_off, diff_end;
  brs_div_t        q_d, q_q;

  // Shift the next dividend bit into each remainder and subtract when it fits.
  always_comb begin
    cand_off = {d_i.r_off, d_i.n_off[QW-1]};
    cand_end = {d_i.r_end, d_i.n_end[QW-1]};
    ge_off   = cand_off >= {1'b0, sb_i};
    ge_end   = cand_end >= {1'b0, sb_i};
    diff_off = ge_off ? cand_off - {1'b0, sb_i} : cand_off;
    diff_end = ge_end ? cand_end - {1'b0, sb_i} : cand_end;
    q_d       = d_i;
    q_d.n_off = {d_i.n_off[QW-2:0], ge_off};
    q_d.n_end = {d_i.n_end[QW-2:0], ge_end};
    q_d.r_off = diff_off[SB_W-1:0];
    q_d.r_end = diff_end[SB_W-1:0];
  end

  // Stage register; reset clears the whole record, the valid bit with it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

/* rtl/brs_emit.sv */
// ----------------------------------------------------------------------------
// Splitter segment emitter
// Holds one split request and sends its segments, one beat each, through
// the output register. Asks for the next request as the last one leaves.
// ----------------------------------------------------------------------------
module brs_emit import brs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  brs_seg_t     item_i,
  output logic         take_o,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  // One-hot codes of the pending segments.
  localparam logic [3:0] SEL_EMPTY = 4'b0001;
  localparam logic [3:0] SEL_HEAD  = 4'b0010;
  localparam logic [3:0] SEL_BULK  = 4'b0100;
  localparam logic [3:0] SEL_TAIL  = 4'b1000;

  brs_seg_t         it_q;
  logic [3:0]       pend_q, pend_d, pend_left, sel, rest, mask;
  logic             out_free, fire;
  logic             vld_q, vld_d;
  logic [159:0]     data_q;
  logic [2:0]       user_q;
  logic             last_q;

  logic [1:0]       kind;
  logic [SEC_W-1:0] start;
  logic [LEN_W-1:0] count, bytes, pos, pos_bulk, pos_tail;
  logic [OIS_W-1:0] ofs;
  logic             rmw;

  // Pick the lowest pending segment and work out whether the item is done.
  always_comb begin
    sel       = pend_q & (~pend_q + 4'd1);
    rest      = pend_q & ~sel;
    out_free  = !vld_q || m_axis_tready;
    fire      = out_free && (pend_q != 4'b0000);
    pend_left = fire ? rest : pend_q;
    take_o    = pend_left == 4'b0000;
    mask      = item_i.nil ? SEL_EMPTY :
                ({item_i.has_tail, 3'b000} | {1'b0, item_i.has_bulk, 2'b00} |
                 {2'b00, item_i.has_head, 1'b0});
    pend_d    = take_o ? (item_i.vld ? mask : 4'b0000) : pend_left;
  end

  // Field values of the selected segment.
  always_comb begin
    pos_bulk = it_q.has_head ? LEN_W'(it_q.hb) : '0;
    pos_tail = pos_bulk + it_q.bulk;
    kind  = KIND_EMPTY;
    start = '0;
    count = '0;
    ofs   = '0;
    bytes = '0;
    pos   = '0;
    rmw   = 1'b0;
    case (sel)
      SEL_HEAD: begin
        kind  = KIND_HEAD;
        start = it_q.s;
        count = LEN_W'(1);
        ofs   = it_q.o[OIS_W-1:0];
        bytes = LEN_W'(it_q.hb);
        rmw   = it_q.op;
      end
      SEL_BULK: begin
        kind  = KIND_BULK;
        start = it_q.sp;
        count = it_q.secs;
        bytes = it_q.bulk;
        pos   = pos_bulk;
      end
      SEL_TAIL: begin
        kind  = KIND_TAIL;
        start = it_q.e;
        count = LEN_W'(1);
        bytes = LEN_W'(it_q.eo);
        pos   = pos_tail;
        rmw   = it_q.op;
      end
      default: begin
        kind = KIND_EMPTY;
      end
    endcase
  end

  // Output valid follows loads and handoffs.
  always_comb begin
    vld_d = vld_q;
    if (fire) begin
      vld_d = 1'b1;
    end else if (m_axis_tready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 4'b0000;
      vld_q  <= 1'b0;
    end else begin
      pend_q <= pend_d;
      vld_q  <= vld_d;
    end
  end

  // Item and output payload registers.
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      it_q <= item_i;
    end
    if (fire) begin
      data_q <= {pos, bytes, ofs, count, start};
      user_q <= {rmw, kind};
      last_q <= rest == 4'b0000;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;
  assign m_axis_tlast  = last_q;

endmodule

/* rtl/byte_range_sector_splitter_top.sv */
// ----------------------------------------------------------------------------
// Byte range sector splitter
// Splits a byte-addressed request into a partial head sector, a run of whole
// sectors and a partial tail sector, clipped to the device size.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat
//  s_axis    in         one request: tdata offset, length; tuser op
//  m_axis    out        one segment: tdata sector fields; tuser kind, rmw;
//                       tlast on the final segment of a request
//  apb       in/out     sector_bytes at 0x0, device_sectors at 0x8
//
//  A request enters in any cycle while s_axis_tready is high. It passes an
//  input register, 49 divider stages (one quotient bit each, start and end
//  offset in parallel), three splitting stages and the emitter, which sends
//  its segments through the output register. The emitter sends one segment
//  per cycle while the output accepts, so a request holds the pipeline until
//  its last segment has left. When the output stalls with a segment pending,
//  the whole pipeline holds its contents. Reset clears all valid bits and
//  loads the register reset values; no clearing pass is needed.
//
module byte_range_sector_splitter_top import brs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Requests.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,   // request_offset[47:0], request_length[79:48]
  input  logic [0:0]   s_axis_tuser,   // op[0]
  // Segments.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata,   // first_sector[47:0], num_sectors[79:48],
                                       // offset_in_sector[95:80],
                                       // segment_bytes[127:96],
                                       // buffer_position[159:128]
  output logic [2:0]   m_axis_tuser,   // segment_kind[1:0], read_modify_write[2]
  output logic         m_axis_tlast,
  // Configuration.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  // Register index codes, taken from paddr bit 3.
  localparam logic REG_SECTOR_BYTES   = 1'b0;
  localparam logic REG_DEVICE_SECTORS = 1'b1;

  logic [SB_W-1:0]  sb_q;
  logic [DEV_W-1:0] dev_q;
  logic             wr_en;
  logic             en;

  brs_div_t         div_d;
  brs_div_t         div_q [QW+1];
  brs_seg_t         p1_d, p1_q, p2_d, p2_q, p3_d, p3_q;

  logic [QW-1:0]    end_u;
  logic             clip;
  logic             head_only;
  logic [SEC_W-1:0] diff;
  logic [SB_W+LEN_W-1:0] prod;

  // ------------------------------------------------------------------
  // Configuration registers.
  // ------------------------------------------------------------------
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_q  <= SB_W'(512);
      dev_q <= '0;
    end else if (wr_en) begin
      unique case (paddr[3])
        REG_SECTOR_BYTES:   sb_q  <= pwdata[SB_W-1:0];
        REG_DEVICE_SECTORS: dev_q <= pwdata[DEV_W-1:0];
        default:            sb_q  <= sb_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_SECTOR_BYTES:   prdata = 64'(sb_q);
      REG_DEVICE_SECTORS: prdata = 64'(dev_q);
      default:            prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Input stage: end offset and the trivially empty cases.
  // ------------------------------------------------------------------
  assign s_axis_tready = en;

  always_comb begin
    div_d       = '0;
    div_d.vld   = s_axis_tvalid;
    div_d.op    = s_axis_tuser[0];
    div_d.nil   = (s_axis_tdata[79:48] == '0) || (sb_q == '0);
    div_d.n_off = QW'(s_axis_tdata[47:0]);
    div_d.n_end = QW'(s_axis_tdata[47:0]) + QW'(s_axis_tdata[79:48]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q[0] <= '0;
    end else if (en) begin
      div_q[0] <= div_d;
    end
  end

  // ------------------------------------------------------------------
  // Divider chain, one quotient bit per stage.
  // ------------------------------------------------------------------
  for (genvar k = 0; k < QW; k++) begin : g_div
    brs_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .sb_i   (sb_q),
      .d_i    (div_q[k]),
      .q_o    (div_q[k+1])
    );
  end

  // ------------------------------------------------------------------
  // Split stage 1: start past end and clipping of the end to the device.
  // ------------------------------------------------------------------
  always_comb begin
    end_u   = div_q[QW].n_end;
    clip    = (end_u > QW'(dev_q)) ||
              ((end_u == QW'(dev_q)) && (div_q[QW].r_end != '0));
    p1_d     = '0;
    p1_d.vld = div_q[QW].vld;
    p1_d.op  = div_q[QW].op;
    p1_d.s   = div_q[QW].n_off[SEC_W-1:0];
    p1_d.o   = div_q[QW].r_off;
    p1_d.nil = div_q[QW].nil || (div_q[QW].n_off[SEC_W-1:0] >= SEC_W'(dev_q));
    p1_d.e   = clip ? SEC_W'(dev_q) : end_u[SEC_W-1:0];
    p1_d.eo  = clip ? '0 : div_q[QW].r_end;
  end

  // ------------------------------------------------------------------
  // Split stage 2: head, bulk run and tail boundaries.
  // ------------------------------------------------------------------
  always_comb begin
    head_only     = (p1_q.o != '0) && (p1_q.e == p1_q.s);
    diff          = p1_q.e - p1_q.s - SEC_W'(p1_q.o != '0);
    p2_d          = p1_q;
    p2_d.has_head = p1_q.o != '0;
    p2_d.sp       = p1_q.s + SEC_W'(p1_q.o != '0);
    p2_d.hb       = head_only ? p1_q.eo - p1_q.o : sb_q - p1_q.o;
    p2_d.secs     = diff[LEN_W-1:0];
    p2_d.has_bulk = !head_only && (diff != '0);
    p2_d.has_tail = !head_only && (p1_q.eo != '0);
  end

  // ------------------------------------------------------------------
  // Split stage 3: bytes of the bulk run.
  // ------------------------------------------------------------------
  always_comb begin
    prod      = p2_q.secs * sb_q;
    p3_d      = p2_q;
    p3_d.bulk = p2_q.has_bulk ? prod[LEN_W-1:0] : '0;
  end

  // Split stage registers; reset clears the whole records.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '0;
      p2_q <= '0;
      p3_q <= '0;
    end else if (en) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
    end
  end

  // ------------------------------------------------------------------
  // Segment emitter and output register.
  // ------------------------------------------------------------------
  brs_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (p3_q),
    .take_o        (en),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
